// File: sv/midi_to_keyboard_report_bridge_top_assert.svh
// assertion macros shared by the bridge modules
`ifndef MIDI_TO_KEYBOARD_REPORT_BRIDGE_TOP_ASSERT_SVH
`define MIDI_TO_KEYBOARD_REPORT_BRIDGE_TOP_ASSERT_SVH

// same-cycle implication
`define MKB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mkb assertion failed");

// next-cycle implication
`define MKB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mkb assertion failed");

`endif

// File: sv/mkb_pkg.sv
// shared constants, codes, types and the idle report table
package mkb_pkg;

  localparam int NUM_KEYS_DEF       = 25;
  localparam int MAX_VELOCITIES_DEF = 5;
  localparam int REPORT_BYTES_DEF   = 27;

  localparam int LEN_W   = 6;
  localparam int BYTE_W  = 8;
  localparam int DATA_W  = 7;
  localparam int IDX_W   = 5;
  localparam int NAV_W   = 11;
  localparam int WHEEL_W = 14;

  localparam logic OP_MIDI   = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [LEN_W-1:0]  MSG_LEN_THREE = 6'd3;
  localparam logic [BYTE_W-1:0] ST_NOTE_OFF   = 8'h80;
  localparam logic [BYTE_W-1:0] ST_NOTE_ON    = 8'h90;
  localparam logic [BYTE_W-1:0] ST_CTRL       = 8'hB0;
  localparam logic [BYTE_W-1:0] ST_BEND       = 8'hE0;

  localparam logic [DATA_W-1:0] CC_MOD       = 7'h01;
  localparam logic [DATA_W-1:0] CC_SUSTAIN   = 7'h40;
  localparam logic [DATA_W-1:0] OD_THRESHOLD = 7'd40;
  localparam logic [BYTE_W-1:0] KEY_BASE_NOTE = 8'd48;

  localparam logic [DATA_W-1:0] NOTE_SELECT    = 7'd36;
  localparam logic [DATA_W-1:0] NOTE_TRIANGLE  = 7'd37;
  localparam logic [DATA_W-1:0] NOTE_LEFT      = 7'd38;
  localparam logic [DATA_W-1:0] NOTE_SQUARE    = 7'd39;
  localparam logic [DATA_W-1:0] NOTE_RIGHT     = 7'd40;
  localparam logic [DATA_W-1:0] NOTE_UP        = 7'd41;
  localparam logic [DATA_W-1:0] NOTE_CIRCLE    = 7'd42;
  localparam logic [DATA_W-1:0] NOTE_DOWN      = 7'd43;
  localparam logic [DATA_W-1:0] NOTE_CROSS     = 7'd44;
  localparam logic [DATA_W-1:0] NOTE_OVERDRIVE = 7'd45;
  localparam logic [DATA_W-1:0] NOTE_START     = 7'd46;

  localparam int NB_CROSS     = 0;
  localparam int NB_CIRCLE    = 1;
  localparam int NB_SQUARE    = 2;
  localparam int NB_TRIANGLE  = 3;
  localparam int NB_START     = 4;
  localparam int NB_SELECT    = 5;
  localparam int NB_OVERDRIVE = 6;
  localparam int NB_UP        = 7;
  localparam int NB_DOWN      = 8;
  localparam int NB_LEFT      = 9;
  localparam int NB_RIGHT     = 10;

  localparam logic [BYTE_W-1:0] HAT_UP       = 8'd0;
  localparam logic [BYTE_W-1:0] HAT_RIGHT    = 8'd2;
  localparam logic [BYTE_W-1:0] HAT_DOWN     = 8'd4;
  localparam logic [BYTE_W-1:0] HAT_LEFT     = 8'd6;
  localparam logic [BYTE_W-1:0] HAT_NEUTRAL  = 8'h08;
  localparam logic [BYTE_W-1:0] WHEEL_MAX    = 8'h75;
  localparam logic [BYTE_W-1:0] WHEEL_CENTER = 8'h80;
  localparam logic [BYTE_W-1:0] WHEEL_DEAD   = 8'd5;
  localparam logic [BYTE_W-1:0] HIGH_BIT     = 8'h80;
  localparam logic [IDX_W-1:0]  VEL_BYTE0    = 5'd8;

  typedef struct packed {
    logic midi_wr;
    logic start;
    logic sweep;
    logic emit;
  } mkb_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic emit_last;
    logic out_free;
  } mkb_sts_t;

  function automatic logic [BYTE_W-1:0] idle_byte(input logic [IDX_W-1:0] b);
    logic [BYTE_W-1:0] v;
    case (b)
      5'd2:                      v = HAT_NEUTRAL;
      5'd3, 5'd4, 5'd5, 5'd6:    v = 8'h80;
      5'd20, 5'd22, 5'd24, 5'd26: v = 8'h02;
      default:                   v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: sv/mkb_in_if.sv
// input channel: midi messages and report requests
interface mkb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        operation;
  logic [mkb_pkg::LEN_W-1:0]   msg_length;
  logic [mkb_pkg::BYTE_W-1:0]  status_byte;
  logic [mkb_pkg::DATA_W-1:0]  data_one;
  logic [mkb_pkg::DATA_W-1:0]  data_two;

  modport source (output valid, operation, msg_length, status_byte, data_one, data_two,
                  input ready);
  modport sink (input valid, operation, msg_length, status_byte, data_one, data_two,
                output ready);
endinterface

// File: sv/mkb_out_if.sv
// result channel: one report byte per beat
interface mkb_out_if;
  logic                       valid;
  logic                       ready;
  logic [mkb_pkg::IDX_W-1:0]  byte_index;
  logic [mkb_pkg::BYTE_W-1:0] byte_value;
  logic                       last_byte;

  modport source (output valid, byte_index, byte_value, last_byte, input ready);
  modport sink (input valid, byte_index, byte_value, last_byte, output ready);
endinterface

// File: sv/mkb_ctrl.sv
// controller state machine: idle, key sweep, byte emission
module mkb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  input  mkb_pkg::mkb_sts_t sts,
  output mkb_pkg::mkb_cmd_t cmd
);
  import mkb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SWEEP = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.midi_wr = accept && (in_operation == OP_MIDI);
    cmd.start   = accept && (in_operation == OP_REPORT);
    case (state_r)
      ST_IDLE: begin
        if (cmd.start) state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

`include "midi_to_keyboard_report_bridge_top_assert.svh"
  `MKB_ASSERT_NEXT(a_start_sweeps, cmd.start, state_r == ST_SWEEP)
  `MKB_ASSERT_NEXT(a_sweep_to_emit, (state_r == ST_SWEEP) && sts.sweep_last,
                   state_r == ST_EMIT)
  `MKB_ASSERT_NEXT(a_last_to_idle, cmd.emit && sts.emit_last, state_r == ST_IDLE)

endmodule

// File: sv/mkb_dpath.sv
// datapath: keyboard state, velocity collection and report byte register
module mkb_dpath #(
  parameter int NUM_KEYS       = mkb_pkg::NUM_KEYS_DEF,
  parameter int MAX_VELOCITIES = mkb_pkg::MAX_VELOCITIES_DEF,
  parameter int REPORT_BYTES   = mkb_pkg::REPORT_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mkb_pkg::mkb_cmd_t          cmd,
  output mkb_pkg::mkb_sts_t          sts,
  input  logic [mkb_pkg::LEN_W-1:0]  msg_length,
  input  logic [mkb_pkg::BYTE_W-1:0] status_byte,
  input  logic [mkb_pkg::DATA_W-1:0] data_one,
  input  logic [mkb_pkg::DATA_W-1:0] data_two,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [mkb_pkg::IDX_W-1:0]  out_byte_index,
  output logic [mkb_pkg::BYTE_W-1:0] out_byte_value,
  output logic                       out_last_byte
);
  import mkb_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CW = $clog2(MAX_VELOCITIES + 1);
  localparam int SW = (MAX_VELOCITIES > 1) ? $clog2(MAX_VELOCITIES) : 1;

  logic [NUM_KEYS-1:0]       key_down_r;
  logic [DATA_W-1:0]         key_vel_r [NUM_KEYS];
  logic [NAV_W-1:0]          nav_r, nav_nxt;
  logic [WHEEL_W-1:0]        wheel_r;
  logic [KW-1:0]             k_r;
  logic [CW-1:0]             cnt_r;
  logic [DATA_W-1:0]         slot_r [MAX_VELOCITIES];
  logic [IDX_W-1:0]          byte_r;
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic [BYTE_W-1:0]         out_val_r;
  logic                      out_last_r;

  logic                      len_ok, is_note, note_on, key_hit, cc_hit;
  logic [BYTE_W-1:0]         note_off;
  logic                      collect;
  logic [31:0]               mask32;
  logic [IDX_W-1:0]          jb;
  logic [BYTE_W-1:0]         pos, wheel_dev, val;

  // midi decode
  assign len_ok   = (msg_length == MSG_LEN_THREE);
  assign is_note  = (status_byte == ST_NOTE_OFF) || (status_byte == ST_NOTE_ON);
  assign note_on  = status_byte[4] && (data_two != '0);
  assign note_off = {1'b0, data_one} - KEY_BASE_NOTE;
  assign key_hit  = ({1'b0, data_one} >= KEY_BASE_NOTE) && (note_off < BYTE_W'(NUM_KEYS));
  assign cc_hit   = (data_one == CC_MOD) || (data_one == CC_SUSTAIN);

  always_comb begin
    nav_nxt = nav_r;
    if (len_ok && is_note) begin
      case (data_one)
        NOTE_CROSS:     nav_nxt[NB_CROSS]     = note_on;
        NOTE_CIRCLE:    nav_nxt[NB_CIRCLE]    = note_on;
        NOTE_SQUARE:    nav_nxt[NB_SQUARE]    = note_on;
        NOTE_TRIANGLE:  nav_nxt[NB_TRIANGLE]  = note_on;
        NOTE_START:     nav_nxt[NB_START]     = note_on;
        NOTE_SELECT:    nav_nxt[NB_SELECT]    = note_on;
        NOTE_OVERDRIVE: nav_nxt[NB_OVERDRIVE] = note_on;
        NOTE_UP:        nav_nxt[NB_UP]        = note_on;
        NOTE_DOWN:      nav_nxt[NB_DOWN]      = note_on;
        NOTE_LEFT:      nav_nxt[NB_LEFT]      = note_on;
        NOTE_RIGHT:     nav_nxt[NB_RIGHT]     = note_on;
        default: ;
      endcase
    end else if (len_ok && (status_byte == ST_CTRL) && cc_hit) begin
      nav_nxt[NB_OVERDRIVE] = (data_two > OD_THRESHOLD);
    end
  end

  assign collect = key_down_r[k_r] && (cnt_r < CW'(MAX_VELOCITIES));

  // report byte for the current index
  always_comb begin
    mask32 = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      mask32[NUM_KEYS-1-i] = key_down_r[i];
    end
  end

  assign jb        = byte_r - VEL_BYTE0;
  assign pos       = wheel_r[WHEEL_W-1 -: BYTE_W];
  assign wheel_dev = (pos >= WHEEL_CENTER) ? (pos - WHEEL_CENTER) : (WHEEL_CENTER - pos);

  always_comb begin
    val = idle_byte(byte_r);
    if ((byte_r >= VEL_BYTE0) && (jb < IDX_W'(MAX_VELOCITIES)) && (jb < IDX_W'(cnt_r))) begin
      val = {1'b0, slot_r[jb[SW-1:0]]};
    end
    case (byte_r)
      5'd0: val = val | {4'b0, nav_r[NB_TRIANGLE], nav_r[NB_CIRCLE], nav_r[NB_CROSS],
                         nav_r[NB_SQUARE]};
      5'd1: val = val | {6'b0, nav_r[NB_START], nav_r[NB_SELECT]};
      5'd2: begin
        if (nav_r[NB_UP])         val = HAT_UP;
        else if (nav_r[NB_DOWN])  val = HAT_DOWN;
        else if (nav_r[NB_LEFT])  val = HAT_LEFT;
        else if (nav_r[NB_RIGHT]) val = HAT_RIGHT;
        else                      val = HAT_NEUTRAL;
      end
      5'd5: val = mask32[24:17];
      5'd6: val = mask32[16:9];
      5'd7: val = mask32[8:1];
      5'd8: val = mask32[0] ? (val | HIGH_BIT) : val;
      5'd13: val = nav_r[NB_OVERDRIVE] ? (val | HIGH_BIT) : val;
      5'd15: begin
        if (wheel_dev >= WHEEL_DEAD) val = (wheel_dev > WHEEL_MAX) ? WHEEL_MAX : wheel_dev;
      end
      default: ;
    endcase
  end

  // control and keyboard state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_down_r  <= '0;
      nav_r       <= '0;
      wheel_r     <= '0;
      k_r         <= '0;
      cnt_r       <= '0;
      byte_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.midi_wr) begin
        nav_r <= nav_nxt;
        if (len_ok && is_note && key_hit) key_down_r[note_off[KW-1:0]] <= note_on;
        if (len_ok && (status_byte == ST_BEND)) wheel_r <= {data_two, data_one};
      end
      if (cmd.start) begin
        k_r    <= '0;
        cnt_r  <= '0;
        byte_r <= '0;
      end
      if (cmd.sweep) begin
        k_r <= k_r + 1'b1;
        if (collect) cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.emit) begin
        byte_r      <= byte_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.midi_wr && len_ok && is_note && key_hit) key_vel_r[note_off[KW-1:0]] <= data_two;
    if (cmd.sweep && collect) slot_r[cnt_r[SW-1:0]] <= key_vel_r[k_r];
    if (cmd.emit) begin
      out_idx_r  <= byte_r;
      out_val_r  <= val;
      out_last_r <= (byte_r == IDX_W'(REPORT_BYTES - 1));
    end
  end

  assign sts.sweep_last = (k_r == KW'(NUM_KEYS - 1));
  assign sts.emit_last  = (byte_r == IDX_W'(REPORT_BYTES - 1));
  assign sts.out_free   = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign out_byte_index = out_idx_r;
  assign out_byte_value = out_val_r;
  assign out_last_byte  = out_last_r;

`include "midi_to_keyboard_report_bridge_top_assert.svh"
  `MKB_ASSERT_NEXT(a_emit_fills, cmd.emit, out_valid_r)
  `MKB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CW'(MAX_VELOCITIES))
  `MKB_ASSERT_NOW(a_last_index, out_valid_r && out_last_r,
                  out_idx_r == IDX_W'(REPORT_BYTES - 1))

endmodule

// File: sv/midi_to_keyboard_report_bridge_top.sv
// top level of the midi to keyboard report bridge
// in_ch takes one beat per item: a three-byte midi message (operation 0) or a
// report request (operation 1); out_ch returns report bytes, one per beat, with
// byte_index counting from 0 and last_byte set on byte REPORT_BYTES-1.
// a midi message updates the keyboard state as soon as it is taken; it produces
// no output beat.
// a report request starts a sweep over the key states, one key per cycle, that
// picks the first MAX_VELOCITIES pressed velocities; then the bytes leave one
// per cycle from the output register while out_ch is not stalled.
// in_ch.ready is low from the request until the last byte is loaded into the
// output register, so the next item waits; a stalled out_ch holds the current
// byte and pauses the byte counter.
// reset (rst_n low, synchronous) clears all keys, buttons and the wheel value
// and drops out_ch.valid.
module midi_to_keyboard_report_bridge_top #(
  parameter int NUM_KEYS       = mkb_pkg::NUM_KEYS_DEF,
  parameter int MAX_VELOCITIES = mkb_pkg::MAX_VELOCITIES_DEF,
  parameter int REPORT_BYTES   = mkb_pkg::REPORT_BYTES_DEF
) (
  input logic        clk,
  input logic        rst_n,
  mkb_in_if.sink     in_ch,
  mkb_out_if.source  out_ch
);
  import mkb_pkg::*;

  mkb_cmd_t cmd;
  mkb_sts_t sts;

  mkb_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .in_ready     (in_ch.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mkb_dpath #(
    .NUM_KEYS       (NUM_KEYS),
    .MAX_VELOCITIES (MAX_VELOCITIES),
    .REPORT_BYTES   (REPORT_BYTES)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .msg_length     (in_ch.msg_length),
    .status_byte    (in_ch.status_byte),
    .data_one       (in_ch.data_one),
    .data_two       (in_ch.data_two),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_byte_index (out_ch.byte_index),
    .out_byte_value (out_ch.byte_value),
    .out_last_byte  (out_ch.last_byte)
  );

endmodule

// File: bench/mkb_report_checker.sv
// checker that tracks keyboard state from midi beats and compares report bytes
module mkb_report_checker (
  input  logic clk,
  input  logic rst_n,
  mkb_in_if    in_ch,
  mkb_out_if   out_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import mkb_pkg::*;

  localparam int KEYS   = NUM_KEYS_DEF;
  localparam int VELS   = MAX_VELOCITIES_DEF;
  localparam int RBYTES = REPORT_BYTES_DEF;

  localparam logic [BYTE_W-1:0] AXIS_IDLE = 8'h80;
  localparam logic [BYTE_W-1:0] PAD_FILL  = 8'h02;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] value;
    logic              last;
  } report_beat_t;

  logic                key_down [KEYS];
  logic [DATA_W-1:0]   key_vel [KEYS];
  logic [NAV_W-1:0]    nav_bits;
  logic [WHEEL_W-1:0]  bend_val;
  report_beat_t        expected_bytes[$];
  int                  err_total = 0;

  function automatic void apply_midi_message(input logic [LEN_W-1:0] len,
                                             input logic [BYTE_W-1:0] st,
                                             input logic [DATA_W-1:0] d1,
                                             input logic [DATA_W-1:0] d2);
    logic pressed;
    int   key;
    if (len != MSG_LEN_THREE) return;
    if (st == ST_NOTE_OFF || st == ST_NOTE_ON) begin
      pressed = (st == ST_NOTE_ON) && (d2 != '0);
      case (d1)
        NOTE_CROSS:     nav_bits[NB_CROSS]     = pressed;
        NOTE_CIRCLE:    nav_bits[NB_CIRCLE]    = pressed;
        NOTE_SQUARE:    nav_bits[NB_SQUARE]    = pressed;
        NOTE_TRIANGLE:  nav_bits[NB_TRIANGLE]  = pressed;
        NOTE_START:     nav_bits[NB_START]     = pressed;
        NOTE_SELECT:    nav_bits[NB_SELECT]    = pressed;
        NOTE_OVERDRIVE: nav_bits[NB_OVERDRIVE] = pressed;
        NOTE_UP:        nav_bits[NB_UP]        = pressed;
        NOTE_DOWN:      nav_bits[NB_DOWN]      = pressed;
        NOTE_LEFT:      nav_bits[NB_LEFT]      = pressed;
        NOTE_RIGHT:     nav_bits[NB_RIGHT]     = pressed;
        default: ;
      endcase
      key = int'(d1) - int'(KEY_BASE_NOTE);
      if (key >= 0 && key < KEYS) begin
        key_down[key] = pressed;
        key_vel[key]  = d2;
      end
    end else if (st == ST_CTRL) begin
      if (d1 == CC_MOD || d1 == CC_SUSTAIN) nav_bits[NB_OVERDRIVE] = (d2 > OD_THRESHOLD);
    end else if (st == ST_BEND) begin
      bend_val = {d2, d1};
    end
  endfunction

  function automatic void queue_expected_report();
    logic [BYTE_W-1:0] rpt [RBYTES];
    logic [KEYS-1:0]   mask;
    logic [BYTE_W-1:0] axis;
    logic [BYTE_W-1:0] axis_dev;
    int                vel_n;
    report_beat_t      beat;
    for (int b = 0; b < RBYTES; b++) begin
      case (b)
        2:              rpt[b] = HAT_NEUTRAL;
        3, 4, 5, 6:     rpt[b] = AXIS_IDLE;
        20, 22, 24, 26: rpt[b] = PAD_FILL;
        default:        rpt[b] = '0;
      endcase
    end
    if (nav_bits[NB_SQUARE])   rpt[0][0] = 1'b1;
    if (nav_bits[NB_CROSS])    rpt[0][1] = 1'b1;
    if (nav_bits[NB_CIRCLE])   rpt[0][2] = 1'b1;
    if (nav_bits[NB_TRIANGLE]) rpt[0][3] = 1'b1;
    if (nav_bits[NB_SELECT])   rpt[1][0] = 1'b1;
    if (nav_bits[NB_START])    rpt[1][1] = 1'b1;
    if (nav_bits[NB_UP])         rpt[2] = HAT_UP;
    else if (nav_bits[NB_DOWN])  rpt[2] = HAT_DOWN;
    else if (nav_bits[NB_LEFT])  rpt[2] = HAT_LEFT;
    else if (nav_bits[NB_RIGHT]) rpt[2] = HAT_RIGHT;
    else                         rpt[2] = HAT_NEUTRAL;
    mask  = '0;
    vel_n = 0;
    for (int k = 0; k < KEYS; k++) begin
      mask = {mask[KEYS-2:0], key_down[k]};
      if (key_down[k] && vel_n < VELS) begin
        rpt[int'(VEL_BYTE0) + vel_n] = {1'b0, key_vel[k]};
        vel_n++;
      end
    end
    rpt[5] = mask[24:17];
    rpt[6] = mask[16:9];
    rpt[7] = mask[8:1];
    if (mask[0]) rpt[8] = rpt[8] | HIGH_BIT;
    if (nav_bits[NB_OVERDRIVE]) rpt[13] = rpt[13] | HIGH_BIT;
    axis     = bend_val[WHEEL_W-1:6];
    axis_dev = (axis >= WHEEL_CENTER) ? axis - WHEEL_CENTER : WHEEL_CENTER - axis;
    if (axis_dev >= WHEEL_DEAD) rpt[15] = (axis_dev > WHEEL_MAX) ? WHEEL_MAX : axis_dev;
    for (int b = 0; b < RBYTES; b++) begin
      beat.idx   = IDX_W'(b);
      beat.value = rpt[b];
      beat.last  = (b == RBYTES - 1);
      expected_bytes.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin
    report_beat_t want;
    if (!rst_n) begin
      for (int k = 0; k < KEYS; k++) begin
        key_down[k] = 1'b0;
        key_vel[k]  = '0;
      end
      nav_bits = '0;
      bend_val = '0;
      expected_bytes.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          if (err_total < 10)
            $display("unexpected report byte: idx %0d value %02h last %0b",
                     out_ch.byte_index, out_ch.byte_value, out_ch.last_byte);
          err_total++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_ch.byte_index !== want.idx || out_ch.byte_value !== want.value ||
              out_ch.last_byte !== want.last) begin
            if (err_total < 10)
              $display("byte mismatch: exp idx %0d val %02h last %0b, got %0d %02h %0b",
                       want.idx, want.value, want.last,
                       out_ch.byte_index, out_ch.byte_value, out_ch.last_byte);
            err_total++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.operation == OP_REPORT) queue_expected_report();
        else apply_midi_message(in_ch.msg_length, in_ch.status_byte,
                                in_ch.data_one, in_ch.data_two);
      end
    end
    fail_count <= err_total;
    pending    <= expected_bytes.size();
  end

endmodule

// File: bench/midi_to_keyboard_report_bridge_top_tb.sv
// testbench top: clock, reset, midi and report request stimulus, verdict
module midi_to_keyboard_report_bridge_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mkb_pkg::*;

  typedef struct packed {
    logic              op;
    logic [LEN_W-1:0]  len;
    logic [BYTE_W-1:0] st;
    logic [DATA_W-1:0] d1;
    logic [DATA_W-1:0] d2;
  } bridge_item_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   hold_requests = 0;

  mkb_in_if  in_ch ();
  mkb_out_if out_ch ();

  midi_to_keyboard_report_bridge_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  mkb_report_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver side, with a long hold-off on request
  initial begin
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else begin
        out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  task automatic send_bridge_item(input bridge_item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.operation   = it.op;
    in_ch.msg_length  = it.len;
    in_ch.status_byte = it.st;
    in_ch.data_one    = it.d1;
    in_ch.data_two    = it.d2;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  function automatic bridge_item_t random_bridge_item(output bit useful);
    bridge_item_t it;
    int           pick;
    pick   = $urandom_range(0, 99);
    useful = 1'b1;
    it.op  = OP_MIDI;
    it.len = MSG_LEN_THREE;
    it.st  = ST_NOTE_ON;
    it.d1  = DATA_W'($urandom);
    it.d2  = DATA_W'($urandom);
    if (pick < 18) begin
      it.op  = OP_REPORT;
      it.len = LEN_W'($urandom);
      it.st  = BYTE_W'($urandom);
    end else if (pick < 60) begin
      it.st = $urandom_range(0, 2) == 0 ? ST_NOTE_OFF : ST_NOTE_ON;
      it.d1 = DATA_W'($urandom_range(int'(NOTE_SELECT), int'(KEY_BASE_NOTE) + NUM_KEYS_DEF - 1));
      if ($urandom_range(0, 5) == 0) it.d2 = '0;
    end else if (pick < 72) begin
      it.st = ST_CTRL;
      it.d1 = $urandom_range(0, 1) ? CC_MOD : CC_SUSTAIN;
      if ($urandom_range(0, 1)) it.d2 = DATA_W'($urandom_range(38, 43));
    end else if (pick < 84) begin
      it.st = ST_BEND;
      if ($urandom_range(0, 2) == 0) it.d2 = DATA_W'($urandom_range(60, 68));
    end else begin
      useful = 1'b0;
      case ($urandom_range(0, 3))
        0: it.len = LEN_W'($urandom);
        1: it.st = BYTE_W'($urandom);
        2: it.st = {ST_NOTE_ON[7:4], 4'($urandom_range(1, 15))};
        default: it.d1 = DATA_W'($urandom_range(int'(KEY_BASE_NOTE) + NUM_KEYS_DEF, 127));
      endcase
    end
    return it;
  endfunction

  initial begin
    int           idle_by_phase [4];
    int           stall_by_phase [4];
    int           counted;
    bit           useful;
    bridge_item_t it;
    idle_by_phase     = '{0, 83, 0, 16};
    stall_by_phase    = '{0, 0, 83, 16};
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.operation   = OP_MIDI;
    in_ch.msg_length  = '0;
    in_ch.status_byte = '0;
    in_ch.data_one    = '0;
    in_ch.data_two    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_bridge_item('{OP_REPORT, MSG_LEN_THREE, ST_NOTE_ON, 7'd0, 7'd0});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, 7'(KEY_BASE_NOTE), 7'd127});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, 7'(KEY_BASE_NOTE + 24), 7'd1});
    for (int n = NOTE_SELECT; n <= NOTE_START; n++)
      send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, 7'(n), 7'd90});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_BEND, 7'd127, 7'd127});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_CTRL, CC_MOD, 7'd41});
    send_bridge_item('{OP_REPORT, 6'd63, 8'hFF, 7'd127, 7'd127});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_OFF, 7'(KEY_BASE_NOTE), 7'd64});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, NOTE_UP, 7'd0});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_CTRL, CC_SUSTAIN, 7'd40});
    send_bridge_item('{OP_MIDI, 6'd2, ST_NOTE_ON, 7'(KEY_BASE_NOTE + 1), 7'd99});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, 8'h91, 7'(KEY_BASE_NOTE + 2), 7'd99});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, 7'(KEY_BASE_NOTE - 1), 7'd50});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_NOTE_ON, 7'(KEY_BASE_NOTE + 25), 7'd50});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_CTRL, 7'd2, 7'd127});
    send_bridge_item('{OP_MIDI, MSG_LEN_THREE, ST_BEND, 7'd0, 7'd64});
    send_bridge_item('{OP_REPORT, 6'd0, 8'h00, 7'd0, 7'd0});

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      if (ph == 0) hold_requests++;
      counted = 0;
      while (counted < 50) begin
        it = random_bridge_item(useful);
        send_bridge_item(it);
        if (useful) counted++;
      end
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
